>>> hdl/bmalloc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmalloc_pkg
// shared types and constants of the bitmap index block allocator
// ----------------------------------------------------------------------------
package bmalloc_pkg;

  // geometry
  localparam int BLK_W           = 7;
  localparam int NUM_BLOCKS      = 1 << BLK_W;
  localparam int MAX_DATA_BLOCKS = 20;
  localparam int FILE_SLOTS      = 16;
  localparam int SLOT_W          = $clog2(FILE_SLOTS);

  // search chunk of the free map handled per cycle
  localparam int CHUNK_W    = 8;
  localparam int CBIT_W     = $clog2(CHUNK_W);
  localparam int NUM_CHUNKS = NUM_BLOCKS / CHUNK_W;
  localparam int CIDX_W     = $clog2(NUM_CHUNKS);

  // entry 0 of a slot's list is the index block, 1..count the data blocks
  localparam int ENT_W  = $clog2(MAX_DATA_BLOCKS + 1);
  localparam int LIST_W = SLOT_W + ENT_W;
  localparam int LIST_DEPTH = 1 << LIST_W;

  // free block counter
  localparam int FCNT_W = $clog2(NUM_BLOCKS + 1);

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CREATE = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOSPACE  = 3'd1;
  localparam logic [2:0] STAT_BUSY     = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_BADCOUNT = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] file_slot;
    logic [4:0] block_count;
    logic [6:0] block_index;
    logic       free_bit;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] block_number;
    logic       is_index_block;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'b001,
    FSM_CREATE = 3'b010,
    FSM_DELETE = 3'b100
  } fsm_e;

endpackage

>>> hdl/bitmap_index_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_index_block_allocator
// indexed file block allocator over a free bitmap
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. Every
// result is shown on res_o for exactly one cycle with res_valid_o high and
// cannot be held off; the final result of a transaction carries last. A set
// request, a rejected create, a rejected delete and mode 3 (no result) leave
// busy_o low. A successful create reports count+1 blocks and also steps past
// each free-map chunk of eight blocks in which it finds no free block; the
// lowest-set-bit search over one eight-bit chunk is the single unit that
// finds each block. A successful delete makes one read of the block list
// memory per cycle, entries 0 to count, and frees each block after its
// registered read. The free map needs no clearing pass; it comes out of
// reset with every block free.
// ----------------------------------------------------------------------------
module bitmap_index_block_allocator
  import bmalloc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  // control state
  fsm_e                    state_q, state_d;
  logic [NUM_BLOCKS-1:0]   free_map_q, free_map_d;
  logic [FCNT_W-1:0]       free_cnt_q, free_cnt_d;
  logic [FILE_SLOTS-1:0]   slot_valid_q, slot_valid_d;
  logic [CIDX_W-1:0]       ptr_q, ptr_d;
  logic [ENT_W-1:0]        ent_q, ent_d;
  logic                    iss_done_q, iss_done_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    res_valid_q, res_valid_d;

  // payload registers
  res_t                    res_q, res_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [ENT_W-1:0]        cnt_q, cnt_d;
  logic [ENT_W-1:0]        slot_cnt_q [FILE_SLOTS];
  logic                    slot_cnt_we;

  // block list memory, one row of entries per slot
  logic [BLK_W-1:0]        list_mem [LIST_DEPTH];
  logic [BLK_W-1:0]        rd_data_q;
  logic                    mem_we, mem_re;
  logic [LIST_W-1:0]       mem_addr;

  // search unit used by create
  logic [CHUNK_W-1:0]      chunk;
  logic [CBIT_W-1:0]       chunk_bit;
  logic [BLK_W-1:0]        alloc_blk;
  logic [FCNT_W-1:0]       need_cnt;
  logic                    bad_count;

  assign chunk = free_map_q[ptr_q*CHUNK_W +: CHUNK_W];

  // lowest free block in the current chunk
  always_comb begin
    chunk_bit = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        chunk_bit = CBIT_W'(i);
      end
    end
  end

  assign alloc_blk = {ptr_q, chunk_bit};
  assign mem_addr  = {slot_q, ent_q};
  assign need_cnt  = FCNT_W'(req_i.block_count) + FCNT_W'(1);
  assign bad_count = (req_i.block_count == '0) ||
                     (32'(req_i.block_count) > MAX_DATA_BLOCKS);

  always_comb begin
    state_d      = state_q;
    free_map_d   = free_map_q;
    free_cnt_d   = free_cnt_q;
    slot_valid_d = slot_valid_q;
    ptr_d        = ptr_q;
    ent_d        = ent_q;
    iss_done_d   = iss_done_q;
    rd_vld_d     = 1'b0;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    slot_cnt_we  = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          res_d.block_number   = '0;
          res_d.is_index_block = 1'b0;
          res_d.last           = 1'b1;
          unique case (req_i.mode)
            MODE_SET: begin
              // direct write of one free bit, counter follows the change
              free_map_d[req_i.block_index] = req_i.free_bit;
              if (req_i.free_bit && !free_map_q[req_i.block_index]) begin
                free_cnt_d = free_cnt_q + FCNT_W'(1);
              end else if (!req_i.free_bit && free_map_q[req_i.block_index]) begin
                free_cnt_d = free_cnt_q - FCNT_W'(1);
              end
              res_d.status       = STAT_OK;
              res_d.block_number = req_i.block_index;
              res_valid_d        = 1'b1;
            end
            MODE_CREATE: begin
              // count, then slot, then space
              if (bad_count) begin
                res_d.status = STAT_BADCOUNT;
                res_valid_d  = 1'b1;
              end else if (slot_valid_q[req_i.file_slot]) begin
                res_d.status = STAT_BUSY;
                res_valid_d  = 1'b1;
              end else if (free_cnt_q < need_cnt) begin
                res_d.status = STAT_NOSPACE;
                res_valid_d  = 1'b1;
              end else begin
                slot_d  = req_i.file_slot;
                cnt_d   = ENT_W'(req_i.block_count);
                ent_d   = '0;
                ptr_d   = '0;
                state_d = FSM_CREATE;
              end
            end
            MODE_DELETE: begin
              if (!slot_valid_q[req_i.file_slot]) begin
                res_d.status = STAT_EMPTY;
                res_valid_d  = 1'b1;
              end else begin
                slot_d     = req_i.file_slot;
                cnt_d      = slot_cnt_q[req_i.file_slot];
                ent_d      = '0;
                iss_done_d = 1'b0;
                state_d    = FSM_DELETE;
              end
            end
            default: begin
              // unused mode, no result
            end
          endcase
        end
      end

      FSM_CREATE: begin
        if (chunk != '0) begin
          // take the lowest free block, record it, report it
          free_map_d[alloc_blk] = 1'b0;
          free_cnt_d            = free_cnt_q - FCNT_W'(1);
          mem_we                = 1'b1;
          res_d.status          = STAT_OK;
          res_d.block_number    = alloc_blk;
          res_d.is_index_block  = (ent_q == '0);
          res_d.last            = (ent_q == cnt_q);
          res_valid_d           = 1'b1;
          if (ent_q == cnt_q) begin
            slot_valid_d[slot_q] = 1'b1;
            slot_cnt_we          = 1'b1;
            state_d              = FSM_IDLE;
          end else begin
            ent_d = ent_q + ENT_W'(1);
          end
        end else begin
          // chunk exhausted, move on
          ptr_d = ptr_q + CIDX_W'(1);
        end
      end

      FSM_DELETE: begin
        // read entry 0..count, free each block in the cycle after its read
        if (!iss_done_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          if (ent_q == cnt_q) begin
            iss_done_d = 1'b1;
          end else begin
            ent_d = ent_q + ENT_W'(1);
          end
        end
        if (rd_vld_q) begin
          free_map_d[rd_data_q] = 1'b1;
          if (!free_map_q[rd_data_q]) begin
            free_cnt_d = free_cnt_q + FCNT_W'(1);
          end
        end
        if (iss_done_q && !rd_vld_q) begin
          slot_valid_d[slot_q] = 1'b0;
          res_d.status         = STAT_OK;
          res_d.block_number   = '0;
          res_d.is_index_block = 1'b0;
          res_d.last           = 1'b1;
          res_valid_d          = 1'b1;
          state_d              = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      free_map_q   <= '1;
      free_cnt_q   <= FCNT_W'(NUM_BLOCKS);
      slot_valid_q <= '0;
      ptr_q        <= '0;
      ent_q        <= '0;
      iss_done_q   <= 1'b0;
      rd_vld_q     <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_map_q   <= free_map_d;
      free_cnt_q   <= free_cnt_d;
      slot_valid_q <= slot_valid_d;
      ptr_q        <= ptr_d;
      ent_q        <= ent_d;
      iss_done_q   <= iss_done_d;
      rd_vld_q     <= rd_vld_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    slot_q <= slot_d;
    cnt_q  <= cnt_d;
    if (slot_cnt_we) begin
      slot_cnt_q[slot_q] <= cnt_q;
    end
  end

  // block list memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem[mem_addr] <= alloc_blk;
    end
    if (mem_re) begin
      rd_data_q <= list_mem[mem_addr];
    end
  end

  assign busy_o      = (state_q != FSM_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // free counter tracks the map exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_map_q) == 32'(free_cnt_q))
    else $error("free counter out of step with free map");

  // the space check guarantees the search never runs off the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_CREATE) && (chunk == '0) |-> (ptr_q != CIDX_W'(NUM_CHUNKS - 1)))
    else $error("block search ran past the end of the free map");

  // an error status always ends its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.status != STAT_OK) |-> res_q.last)
    else $error("error result not marked last");

  // create finishes by marking its slot valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_CREATE) && res_valid_d && res_d.last |=> slot_valid_q[slot_q])
    else $error("created slot not marked valid");
`endif

endmodule
